FILE: sv/bpa_pkg.sv
// Shared constants and codes for the buddy page allocator.
package bpa_pkg;

  localparam int PAGE_COUNT_DEF  = 1024;
  localparam int MAX_ORDER_DEF   = 10;
  localparam int PAGE_SHIFT      = 12;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 23;
  localparam int CNT_W      = 11;
  localparam int ORD_OUT_W  = 4;
  localparam int PAGES_W    = SIZE_W - PAGE_SHIFT + 1;
  localparam int WANT_W     = 4;

  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_QUERY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_BAD_FREE = 2'd2,
    ST_NOT_INIT = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_BASE_ADDRESS = 1'b0,
    REG_REGION_PAGES = 1'b1
  } reg_index_t;

endpackage

FILE: sv/bpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/buddy_page_allocator.sv
// Buddy page allocator top level: request sequencer, free lists and page metadata.
//
// Requests arrive on the s_axis channel (mode in tuser, size and address in tdata);
// one response per request leaves on m_axis (status in tuser, address, order and
// counters in tdata). Registers base_address and region_pages are written through
// cfg_we/cfg_index/cfg_data and take effect at the next init request.
//
// The block handles one request at a time and drops tready from the accepting
// transfer until the response is loaded into the output register. A response may
// wait in that register while the next request is taken.
//   query / not initialized : straight to the done state
//   allocate                : search orders upward, unlink, then split level by level
//   free                    : check the address, then merge level by level
//   init                    : metadata clearing over all PAGE_COUNT entries, then
//                             carving blocks from the top order down
// Each metadata RAM has a single write port, and every list walk goes through the
// shared index register and one RAM read a step.
// Reset (rst, synchronous) empties the sequencer and the output register and marks
// the allocator as not initialized; the metadata RAMs hold no reset value and the
// init request sweeps the flag bits clear. When the receiver stalls, the response
// holds in place and a finished request waits in the done state.
module buddy_page_allocator #(
  parameter int PAGE_COUNT      = bpa_pkg::PAGE_COUNT_DEF,
  parameter int MAX_BLOCK_ORDER = bpa_pkg::MAX_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [bpa_pkg::ADDR_W-1:0]    cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [22:0] size_bytes, [70:23] address, [71] zero
  input  logic [bpa_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // [1:0] mode
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [47:0] block_address, [51:48] order, [62:52] pages_in_use,
  // [73:63] pages_free, [74] memory_critical, [79:75] zero
  output logic [bpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // [1:0] status
  output logic [1:0]                    m_axis_tuser
);

  import bpa_pkg::*;

  localparam int IW  = $clog2(PAGE_COUNT);
  localparam int CW  = $clog2(PAGE_COUNT + 1);
  localparam int OW  = $clog2(MAX_BLOCK_ORDER + 1);
  localparam int KW  = $clog2(MAX_BLOCK_ORDER + 2);
  localparam int SW  = (CW > MAX_BLOCK_ORDER + 1) ? CW : MAX_BLOCK_ORDER + 2;
  localparam int LW  = IW + 1;
  localparam int MW  = OW + 2;
  localparam int NL  = MAX_BLOCK_ORDER + 1;

  typedef enum logic [17:0] {
    S_IDLE   = 18'h00001,
    S_CLEAR  = 18'h00002,
    S_CARVE  = 18'h00004,
    S_PUSH_A = 18'h00008,
    S_PUSH_B = 18'h00010,
    S_A_PREP = 18'h00020,
    S_SEARCH = 18'h00040,
    S_UL_RD  = 18'h00080,
    S_UL_WR  = 18'h00100,
    S_SPLIT  = 18'h00200,
    S_F_SUB  = 18'h00400,
    S_F_CHK  = 18'h00800,
    S_F_RD   = 18'h01000,
    S_F_WT   = 18'h02000,
    S_MERGE  = 18'h04000,
    S_M_RD   = 18'h08000,
    S_M_CHK  = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  // metadata entry: {order, free head, alloc head}
  typedef struct packed {
    logic [OW-1:0] ord;
    logic          free_head;
    logic          alloc_head;
  } meta_t;

  typedef struct packed {
    logic          ok;
    logic [IW-1:0] idx;
  } link_t;

  state_t state;

  // configuration and latched region
  logic [ADDR_W-1:0] base_cfg;
  logic [CNT_W-1:0]  region_cfg;
  logic [ADDR_W-1:0] act_base;
  logic [CW-1:0]     act_pages;
  logic              ready;
  logic [SW-1:0]     used;

  // free list heads
  logic [IW-1:0] head [NL];
  logic [NL-1:0] head_ok;

  // request and work registers
  mode_t              op;
  logic [SIZE_W-1:0]  req_size;
  logic [ADDR_W-1:0]  req_addr;
  logic [ADDR_W:0]    off;
  logic [WANT_W-1:0]  want;
  logic [KW-1:0]      ord;
  logic [IW-1:0]      idx;
  logic [IW-1:0]      cur;
  logic [SW-1:0]      left;

  // response fields
  status_t            res_status;
  logic [ADDR_W-1:0]  res_addr;
  logic [ORD_OUT_W-1:0] res_order;

  // RAM ports
  logic          meta_we, next_we, prev_we;
  logic [IW-1:0] meta_wa, next_wa, prev_wa;
  meta_t         meta_wd, meta_rd;
  link_t         next_wd, next_rd, prev_wd, prev_rd;
  logic [MW-1:0] meta_rd_raw;
  logic [LW-1:0] next_rd_raw, prev_rd_raw;

  logic [OW-1:0]      ho;
  logic [SW-1:0]      span;
  logic [SW-1:0]      bud;
  logic [PAGES_W-1:0] pages;
  logic [WANT_W-1:0]  want_calc;
  logic               in_xfer;
  logic               out_free;

  assign ho       = ord[OW-1:0];
  assign span     = SW'(1) << ord;
  assign bud      = SW'(cur) ^ span;
  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  assign meta_rd = meta_t'(meta_rd_raw);
  assign next_rd = link_t'(next_rd_raw);
  assign prev_rd = link_t'(prev_rd_raw);

  // round the request up to whole pages, then to a power of two
  assign pages = PAGES_W'(({1'b0, req_size} + 24'd4095) >> PAGE_SHIFT);

  always_comb begin
    want_calc = WANT_W'(PAGES_W - 1);
    for (int i = PAGES_W - 1; i >= 0; i--) begin
      if ((PAGES_W'(1) << i) >= pages) begin
        want_calc = WANT_W'(i);
      end
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      base_cfg   <= '0;
      region_cfg <= CNT_W'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BASE_ADDRESS: base_cfg   <= cfg_data;
        REG_REGION_PAGES: region_cfg <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // RAM write steering
  always_comb begin
    meta_we = 1'b0;
    meta_wa = idx;
    meta_wd = '0;
    next_we = 1'b0;
    next_wa = idx;
    next_wd = '0;
    prev_we = 1'b0;
    prev_wa = idx;
    prev_wd = '0;
    case (state)
      S_CLEAR: begin
        meta_we = 1'b1;
      end
      S_PUSH_A: begin
        meta_we = 1'b1;
        meta_wd = '{ord: ho, free_head: 1'b1, alloc_head: 1'b0};
        next_we = 1'b1;
        next_wd = '{ok: head_ok[ho], idx: head[ho]};
        prev_we = 1'b1;
      end
      S_PUSH_B: begin
        // link the old head back to the new one
        prev_we = head_ok[ho];
        prev_wa = head[ho];
        prev_wd = '{ok: 1'b1, idx: idx};
      end
      S_UL_WR: begin
        meta_we = 1'b1;
        meta_wd = '{ord: ho, free_head: 1'b0, alloc_head: 1'b0};
        next_we = prev_rd.ok;
        next_wa = prev_rd.idx;
        next_wd = next_rd;
        prev_we = next_rd.ok;
        prev_wa = next_rd.idx;
        prev_wd = prev_rd;
      end
      S_SPLIT: begin
        if (32'(ord) <= 32'(want)) begin
          meta_we = 1'b1;
          meta_wd = '{ord: OW'(want), free_head: 1'b0, alloc_head: 1'b1};
        end
      end
      S_F_WT: begin
        if (meta_rd.alloc_head) begin
          meta_we = 1'b1;
          meta_wd = '{ord: meta_rd.ord, free_head: 1'b0, alloc_head: 1'b0};
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ready         <= 1'b0;
      used          <= '0;
      head_ok       <= '0;
      act_pages     <= '0;
      act_base      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            op         <= mode_t'(s_axis_tuser);
            req_size   <= s_axis_tdata[SIZE_W-1:0];
            req_addr   <= s_axis_tdata[SIZE_W +: ADDR_W];
            res_status <= (mode_t'(s_axis_tuser) != MODE_INIT && !ready) ? ST_NOT_INIT
                                                                           : ST_OK;
            res_addr   <= '0;
            res_order  <= '0;
            if (mode_t'(s_axis_tuser) == MODE_INIT) begin
              // latch the region and drop every list
              act_base <= base_cfg;
              act_pages <= (32'(region_cfg) > PAGE_COUNT) ? CW'(PAGE_COUNT)
                                                          : CW'(region_cfg);
              used     <= '0;
              head_ok  <= '0;
              idx      <= '0;
              state    <= S_CLEAR;
            end else if (!ready) begin
              state      <= S_DONE;
            end else if (mode_t'(s_axis_tuser) == MODE_ALLOC) begin
              state <= S_A_PREP;
            end else if (mode_t'(s_axis_tuser) == MODE_FREE) begin
              state <= S_F_SUB;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_CLEAR: begin
          if (idx == IW'(PAGE_COUNT - 1)) begin
            idx   <= '0;
            left  <= SW'(act_pages);
            ord   <= KW'(MAX_BLOCK_ORDER);
            state <= S_CARVE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_CARVE: begin
          if (left >= span) begin
            state <= S_PUSH_A;
          end else if (ord == '0) begin
            ready <= 1'b1;
            state <= S_DONE;
          end else begin
            ord <= ord - 1'b1;
          end
        end
        S_PUSH_A: begin
          state <= S_PUSH_B;
        end
        S_PUSH_B: begin
          head[ho]    <= idx;
          head_ok[ho] <= 1'b1;
          case (op)
            MODE_INIT: begin
              idx   <= idx + IW'(span);
              left  <= left - span;
              state <= S_CARVE;
            end
            MODE_ALLOC: begin
              // continue with the upper half
              idx   <= idx + IW'(span);
              state <= S_SPLIT;
            end
            default: state <= S_DONE;
          endcase
        end
        S_A_PREP: begin
          want <= want_calc;
          if (32'(want_calc) > MAX_BLOCK_ORDER) begin
            res_status <= ST_NO_MEM;
            state      <= S_DONE;
          end else begin
            ord   <= KW'(want_calc);
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (32'(ord) > MAX_BLOCK_ORDER) begin
            res_status <= ST_NO_MEM;
            state      <= S_DONE;
          end else if (head_ok[ho]) begin
            idx   <= head[ho];
            state <= S_UL_RD;
          end else begin
            ord <= ord + 1'b1;
          end
        end
        S_UL_RD: begin
          state <= S_UL_WR;
        end
        S_UL_WR: begin
          if (!prev_rd.ok) begin
            head[ho]    <= next_rd.idx;
            head_ok[ho] <= next_rd.ok;
          end
          if (op == MODE_ALLOC) begin
            state <= S_SPLIT;
          end else begin
            cur   <= cur & ~IW'(span);
            ord   <= ord + 1'b1;
            state <= S_MERGE;
          end
        end
        S_SPLIT: begin
          if (32'(ord) > 32'(want)) begin
            ord   <= ord - 1'b1;
            state <= S_PUSH_A;
          end else begin
            used      <= used + (SW'(1) << want);
            res_order <= ORD_OUT_W'(want);
            res_addr  <= act_base + ADDR_W'({idx, {PAGE_SHIFT{1'b0}}});
            state     <= S_DONE;
          end
        end
        S_F_SUB: begin
          off   <= {1'b0, req_addr} - {1'b0, act_base};
          state <= S_F_CHK;
        end
        S_F_CHK: begin
          if (off[ADDR_W] || off[PAGE_SHIFT-1:0] != '0 ||
              ADDR_W'(off[ADDR_W-1:PAGE_SHIFT]) >= ADDR_W'(act_pages)) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            idx   <= off[IW+PAGE_SHIFT-1:PAGE_SHIFT];
            state <= S_F_RD;
          end
        end
        S_F_RD: begin
          state <= S_F_WT;
        end
        S_F_WT: begin
          if (!meta_rd.alloc_head) begin
            res_status <= ST_BAD_FREE;
            state      <= S_DONE;
          end else begin
            res_order <= ORD_OUT_W'(meta_rd.ord);
            used      <= used - (SW'(1) << meta_rd.ord);
            cur       <= idx;
            ord       <= KW'(meta_rd.ord);
            state     <= S_MERGE;
          end
        end
        S_MERGE: begin
          // stop at the top order or where the buddy leaves the region
          if (32'(ord) >= MAX_BLOCK_ORDER || bud >= SW'(act_pages) ||
              SW'(act_pages) - bud < span) begin
            idx   <= cur;
            state <= S_PUSH_A;
          end else begin
            idx   <= bud[IW-1:0];
            state <= S_M_RD;
          end
        end
        S_M_RD: begin
          state <= S_M_CHK;
        end
        S_M_CHK: begin
          if (meta_rd.free_head && meta_rd.ord == ho) begin
            state <= S_UL_WR;
          end else begin
            idx   <= cur;
            state <= S_PUSH_A;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output valid: raise when a response loads, drop after its transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // response register
  logic [CNT_W-1:0] out_in_use, out_free_pages;
  logic             out_crit;

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      m_axis_tuser <= res_status;
      m_axis_tdata <= {5'b0, out_crit, out_free_pages, out_in_use, res_order, res_addr};
    end
  end

  always_comb begin
    if (ready) begin
      out_in_use     = CNT_W'(used);
      out_free_pages = CNT_W'(SW'(act_pages) - used);
      out_crit       = {used, 1'b0} >= {1'b0, SW'(act_pages)};
    end else begin
      out_in_use     = '0;
      out_free_pages = '0;
      out_crit       = 1'b0;
    end
  end

  bpa_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_wa),
    .wdata (meta_wd),
    .raddr (idx),
    .rdata (meta_rd_raw)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT)) u_next (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_wa),
    .wdata (next_wd),
    .raddr (idx),
    .rdata (next_rd_raw)
  );

  bpa_ram #(.WIDTH(LW), .DEPTH(PAGE_COUNT)) u_prev (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_wa),
    .wdata (prev_wd),
    .raddr (idx),
    .rdata (prev_rd_raw)
  );

  // allocations never hold more pages than the region
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    ready |-> used <= SW'(act_pages))
    else $error("pages in use exceed region");

  // the input is closed in the cycle after a request is accepted
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input reopened right after transfer");

  // the allocator becomes ready only when carving ends
  a_ready_from_carve: assert property (@(posedge clk) disable iff (rst)
    $rose(ready) |-> $past(state) == S_CARVE)
    else $error("ready set outside carving");

  // a finished request with a free output register shows a response
  a_done_shows: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> m_axis_tvalid)
    else $error("response not presented");

endmodule
